/* rtl/core/led_keyframe_pattern_player_defines.svh */
// Assertion macros used by the keyframe player top level.
`ifndef LED_KEYFRAME_PATTERN_PLAYER_DEFINES_SVH
`define LED_KEYFRAME_PATTERN_PLAYER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define LKP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define LKP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lkp_pkg.sv */
// Types, constants and microcode table of the keyframe pattern player.
package lkp_pkg;

  localparam int unsigned MaxKeyframesDef = 16;
  localparam int unsigned TimeWidthDef    = 24;
  localparam logic [7:0]  TickPeriodReset = 8'd10;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_START = 2'd2,
    REQ_SET   = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [3:0]  key_index;
    logic [23:0] key_time;
    logic        key_on;
    logic [4:0]  key_count;
    logic [23:0] cycle_ms;
    logic        set_level;
  } in_item_t;

  typedef struct packed {
    logic led_on;
    logic is_running;
    logic is_repeating;
  } out_item_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_SET,
    OP_ADD_TICK,
    OP_LOAD,
    OP_CLR_I,
    OP_INC_I,
    OP_WR_ACTIVE,
    OP_ARM,
    OP_WRAP,
    OP_RD_STEP,
    OP_APPLY,
    OP_END,
    OP_EMIT
  } uop_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_BEAT,
    C_REQ_TICK,
    C_REQ_LOAD,
    C_REQ_START,
    C_NOT_PLAYING,
    C_EMPTY,
    C_HDR_DIFF,
    C_MISMATCH,
    C_I_LT_CNT,
    C_STEP_END,
    C_NOT_DUE,
    C_STEP_LT_CNT,
    C_OUT_BUSY
  } cond_e;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    uop_e op;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic req_tick;
    logic req_load;
    logic req_start;
    logic not_playing;
    logic empty;
    logic hdr_diff;
    logic mismatch;
    logic i_lt_cnt;
    logic step_end;
    logic not_due;
    logic step_lt_cnt;
  } dp_status_t;

  // Microcode addresses.
  localparam upc_t UA_IDLE     = 5'd0;
  localparam upc_t UA_DISP0    = 5'd1;
  localparam upc_t UA_DISP1    = 5'd2;
  localparam upc_t UA_DISP2    = 5'd3;
  localparam upc_t UA_SET      = 5'd4;
  localparam upc_t UA_TICK     = 5'd5;
  localparam upc_t UA_TICK_ADD = 5'd6;
  localparam upc_t UA_LOAD     = 5'd7;
  localparam upc_t UA_START    = 5'd8;
  localparam upc_t UA_HDR      = 5'd9;
  localparam upc_t UA_CMP_RD   = 5'd10;
  localparam upc_t UA_CMP_CHK  = 5'd11;
  localparam upc_t UA_CMP_LOOP = 5'd12;
  localparam upc_t UA_CMP_SAME = 5'd13;
  localparam upc_t UA_COPY     = 5'd14;
  localparam upc_t UA_CP_RD    = 5'd15;
  localparam upc_t UA_CP_WR    = 5'd16;
  localparam upc_t UA_CP_LOOP  = 5'd17;
  localparam upc_t UA_ARM      = 5'd18;
  localparam upc_t UA_ADV      = 5'd19;
  localparam upc_t UA_ADV_RD   = 5'd20;
  localparam upc_t UA_ADV_APP  = 5'd21;
  localparam upc_t UA_ADV_LOOP = 5'd22;
  localparam upc_t UA_END      = 5'd23;
  localparam upc_t UA_OUT      = 5'd24;
  localparam upc_t UA_RET      = 5'd25;

  // A condition that holds jumps to the target, otherwise fall through.
  function automatic uword_t lkp_ucode(upc_t addr);
    uword_t w;
    case (addr)
      UA_IDLE:     w = '{op: OP_LATCH,     cond: C_NO_BEAT,     target: UA_IDLE};
      UA_DISP0:    w = '{op: OP_NOP,       cond: C_REQ_TICK,    target: UA_TICK};
      UA_DISP1:    w = '{op: OP_NOP,       cond: C_REQ_LOAD,    target: UA_LOAD};
      UA_DISP2:    w = '{op: OP_NOP,       cond: C_REQ_START,   target: UA_START};
      UA_SET:      w = '{op: OP_SET,       cond: C_ALWAYS,      target: UA_OUT};
      UA_TICK:     w = '{op: OP_NOP,       cond: C_NOT_PLAYING, target: UA_OUT};
      UA_TICK_ADD: w = '{op: OP_ADD_TICK,  cond: C_ALWAYS,      target: UA_ADV};
      UA_LOAD:     w = '{op: OP_LOAD,      cond: C_ALWAYS,      target: UA_OUT};
      UA_START:    w = '{op: OP_NOP,       cond: C_EMPTY,       target: UA_OUT};
      UA_HDR:      w = '{op: OP_CLR_I,     cond: C_HDR_DIFF,    target: UA_COPY};
      UA_CMP_RD:   w = '{op: OP_NOP,       cond: C_NEVER,       target: UA_IDLE};
      UA_CMP_CHK:  w = '{op: OP_INC_I,     cond: C_MISMATCH,    target: UA_COPY};
      UA_CMP_LOOP: w = '{op: OP_NOP,       cond: C_I_LT_CNT,    target: UA_CMP_RD};
      UA_CMP_SAME: w = '{op: OP_NOP,       cond: C_ALWAYS,      target: UA_OUT};
      UA_COPY:     w = '{op: OP_CLR_I,     cond: C_NEVER,       target: UA_IDLE};
      UA_CP_RD:    w = '{op: OP_NOP,       cond: C_NEVER,       target: UA_IDLE};
      UA_CP_WR:    w = '{op: OP_WR_ACTIVE, cond: C_NEVER,       target: UA_IDLE};
      UA_CP_LOOP:  w = '{op: OP_NOP,       cond: C_I_LT_CNT,    target: UA_CP_RD};
      UA_ARM:      w = '{op: OP_ARM,       cond: C_NEVER,       target: UA_IDLE};
      UA_ADV:      w = '{op: OP_WRAP,      cond: C_NEVER,       target: UA_IDLE};
      UA_ADV_RD:   w = '{op: OP_RD_STEP,   cond: C_STEP_END,    target: UA_END};
      UA_ADV_APP:  w = '{op: OP_APPLY,     cond: C_NOT_DUE,     target: UA_OUT};
      UA_ADV_LOOP: w = '{op: OP_NOP,       cond: C_STEP_LT_CNT, target: UA_ADV};
      UA_END:      w = '{op: OP_END,       cond: C_ALWAYS,      target: UA_OUT};
      UA_OUT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY,    target: UA_OUT};
      UA_RET:      w = '{op: OP_NOP,       cond: C_ALWAYS,      target: UA_IDLE};
      default:     w = '{op: OP_NOP,       cond: C_ALWAYS,      target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/led_keyframe_pattern_player.sv */
// Top level of the keyframe LED pattern player.
// One item at a time runs through a microcoded sequencer that drives a datapath
// with the keyframe tables, which have registered reads. A tick applies the
// keyframes that are due; a start copies its keyframes in and restarts play
// unless they match the running pattern. The result sits in an output register,
// so the next item is taken while it waits; a result that is still stalled when
// the next one is ready holds the sequencer until the sink takes it. No clearing
// pass after reset.
`include "led_keyframe_pattern_player_defines.svh"

module led_keyframe_pattern_player #(
  parameter int unsigned MAX_KEYFRAMES = lkp_pkg::MaxKeyframesDef,
  parameter int unsigned TIME_WIDTH    = lkp_pkg::TimeWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lkp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lkp_pkg::out_item_t out_data_o
);
  import lkp_pkg::*;

  logic [7:0] tick_q;
  ctrl_t      ctrl;
  dp_status_t status;
  out_item_t  result, out_q;
  logic       out_valid_q, out_busy, in_beat, emit;

  assign in_stall_o = !ctrl.idle;
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;
  assign emit       = (ctrl.op == OP_EMIT) && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TickPeriodReset;
    end else if (cfg_we_i) begin
      tick_q <= cfg_wdata_i;
    end
  end

  lkp_sequencer u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .out_busy_i (out_busy),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  lkp_datapath #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .op_i          (ctrl.op),
    .in_data_i,
    .tick_period_i (tick_q),
    .status_o      (status),
    .result_o      (result)
  );

  // Hold the result beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LKP_ASSERT_NOW(a_emit_only, $rose(out_valid_q), $past(ctrl.op == OP_EMIT), "result without emit step")
  `LKP_ASSERT_NOW(a_rep_run, out_valid_q && out_q.is_repeating, out_q.is_running, "repeat while stopped")
  `LKP_ASSERT_NEXT(a_beat_leaves_idle, in_beat, !ctrl.idle, "sequencer stayed idle after beat")

endmodule

/* rtl/core/lkp_sequencer.sv */
// Microcode step counter and jump logic of the keyframe pattern player.
module lkp_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_busy_i,
  input  lkp_pkg::dp_status_t status_i,
  output lkp_pkg::ctrl_t      ctrl_o
);
  import lkp_pkg::*;

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   take;

  assign uw = lkp_ucode(upc_q);

  always_comb begin
    case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_BEAT:     take = !in_valid_i;
      C_REQ_TICK:    take = status_i.req_tick;
      C_REQ_LOAD:    take = status_i.req_load;
      C_REQ_START:   take = status_i.req_start;
      C_NOT_PLAYING: take = status_i.not_playing;
      C_EMPTY:       take = status_i.empty;
      C_HDR_DIFF:    take = status_i.hdr_diff;
      C_MISMATCH:    take = status_i.mismatch;
      C_I_LT_CNT:    take = status_i.i_lt_cnt;
      C_STEP_END:    take = status_i.step_end;
      C_NOT_DUE:     take = status_i.not_due;
      C_STEP_LT_CNT: take = status_i.step_lt_cnt;
      C_OUT_BUSY:    take = out_busy_i;
      default:       take = 1'b0;
    endcase
    upc_d = take ? uw.target : upc_q + upc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.op   = uw.op;
  assign ctrl_o.idle = (upc_q == UA_IDLE);

endmodule

/* rtl/core/lkp_datapath.sv */
// Keyframe tables, timing registers and player state of the pattern player.
module lkp_datapath #(
  parameter int unsigned MAX_KEYFRAMES = lkp_pkg::MaxKeyframesDef,
  parameter int unsigned TIME_WIDTH    = lkp_pkg::TimeWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkp_pkg::uop_e       op_i,
  input  lkp_pkg::in_item_t   in_data_i,
  input  logic [7:0]          tick_period_i,
  output lkp_pkg::dp_status_t status_o,
  output lkp_pkg::out_item_t  result_o
);
  import lkp_pkg::*;

  localparam int unsigned IW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYFRAMES + 1);
  localparam int unsigned TW = TIME_WIDTH;

  // Table word: time above, level in bit 0.
  logic [TW:0] stg_mem [MAX_KEYFRAMES];
  logic [TW:0] act_mem [MAX_KEYFRAMES];
  logic [MAX_KEYFRAMES-1:0] stg_vld_q, stg_vld_d;
  logic [TW:0] stg_rd_q, act_rd_q, stg_word;
  logic        stg_rd_vld_q;

  in_item_t    req_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] step_q, step_d;
  logic [CW-1:0] i_q, i_d;
  logic [TW-1:0] elapsed_q, elapsed_d;
  logic [TW-1:0] cycle_q, cycle_d;
  logic          playing_q, playing_d;
  logic          led_q, led_d;

  logic [TW-1:0] key_tw, cyc_tw;
  logic [TW:0]   tick_sum;
  logic [IW-1:0] ld_addr, i_idx, act_raddr;
  logic          ld_ok, stg_we, act_we, wrap_hit, due;

  assign key_tw    = TW'(req_q.key_time);
  assign cyc_tw    = TW'(req_q.cycle_ms);
  assign ld_addr   = IW'(req_q.key_index);
  assign ld_ok     = 32'(req_q.key_index) < MAX_KEYFRAMES;
  assign i_idx     = i_q[IW-1:0];
  assign act_raddr = (op_i == OP_RD_STEP) ? step_q[IW-1:0] : i_idx;
  assign stg_word  = stg_rd_vld_q ? stg_rd_q : '0;
  assign stg_we    = (op_i == OP_LOAD) && ld_ok;
  assign act_we    = (op_i == OP_WR_ACTIVE);
  assign tick_sum  = {1'b0, elapsed_q} + (TW + 1)'(tick_period_i);
  assign wrap_hit  = (cycle_q != '0) && (elapsed_q >= cycle_q);
  assign due       = elapsed_q >= act_rd_q[TW:1];

  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      stg_mem[ld_addr] <= {key_tw, req_q.key_on};
    end
    stg_rd_q     <= stg_mem[i_idx];
    stg_rd_vld_q <= stg_vld_q[i_idx];
  end

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[i_idx] <= stg_word;
    end
    act_rd_q <= act_mem[act_raddr];
  end

  // Hold the item and its clamped keyframe count.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LATCH) begin
      req_q <= in_data_i;
      cnt_q <= (32'(in_data_i.key_count) > MAX_KEYFRAMES) ?
               CW'(MAX_KEYFRAMES) : CW'(in_data_i.key_count);
    end
  end

  always_comb begin
    stg_vld_d = stg_vld_q;
    count_d   = count_q;
    step_d    = step_q;
    i_d       = i_q;
    elapsed_d = elapsed_q;
    cycle_d   = cycle_q;
    playing_d = playing_q;
    led_d     = led_q;
    case (op_i)
      OP_SET: begin
        playing_d = 1'b0;
        led_d     = req_q.set_level;
      end
      OP_ADD_TICK: begin
        elapsed_d = tick_sum[TW] ? '1 : tick_sum[TW-1:0];
      end
      OP_LOAD: begin
        if (ld_ok) stg_vld_d[ld_addr] = 1'b1;
      end
      OP_CLR_I: i_d = '0;
      OP_INC_I: i_d = i_q + CW'(1);
      OP_WR_ACTIVE: i_d = i_q + CW'(1);
      OP_ARM: begin
        count_d   = cnt_q;
        step_d    = '0;
        elapsed_d = '0;
        cycle_d   = cyc_tw;
        playing_d = 1'b1;
      end
      OP_WRAP: begin
        // Restart the cycle and drop the overshoot.
        if (wrap_hit) begin
          step_d    = '0;
          elapsed_d = '0;
        end
      end
      OP_APPLY: begin
        if (due) begin
          led_d  = act_rd_q[0];
          step_d = step_q + CW'(1);
        end
      end
      OP_END: begin
        if (cycle_q == '0) playing_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
      count_q   <= '0;
      step_q    <= '0;
      i_q       <= '0;
      elapsed_q <= '0;
      cycle_q   <= '0;
      playing_q <= 1'b0;
      led_q     <= 1'b0;
    end else begin
      stg_vld_q <= stg_vld_d;
      count_q   <= count_d;
      step_q    <= step_d;
      i_q       <= i_d;
      elapsed_q <= elapsed_d;
      cycle_q   <= cycle_d;
      playing_q <= playing_d;
      led_q     <= led_d;
    end
  end

  assign status_o.req_tick    = (req_q.req_type == REQ_TICK);
  assign status_o.req_load    = (req_q.req_type == REQ_LOAD);
  assign status_o.req_start   = (req_q.req_type == REQ_START);
  assign status_o.not_playing = !playing_q;
  assign status_o.empty       = (cnt_q == '0);
  assign status_o.hdr_diff    = !(playing_q && (cycle_q == cyc_tw) && (count_q == cnt_q));
  assign status_o.mismatch    = (act_rd_q != stg_word);
  assign status_o.i_lt_cnt    = (i_q < cnt_q);
  assign status_o.step_end    = (step_q >= count_q);
  assign status_o.not_due     = !due;
  assign status_o.step_lt_cnt = (step_q < count_q);

  assign result_o.led_on       = led_q;
  assign result_o.is_running   = playing_q;
  assign result_o.is_repeating = playing_q && (cycle_q != '0);

endmodule
